>>> rtl/uhr_pkg.sv
`default_nettype none
package uhr_pkg;

    localparam int RING_DEPTH = 256;
    localparam int RING_AW    = $clog2(RING_DEPTH);
    localparam int BASE_DEPTH = 64;
    localparam int BASE_AW    = $clog2(BASE_DEPTH);

    typedef logic [RING_AW-1:0] t_rptr;
    typedef logic [BASE_AW-1:0] t_bptr;

    typedef enum logic [2:0] {
        CMD_ADD  = 3'd0,
        CMD_UNDO = 3'd1,
        CMD_REDO = 3'd2,
        CMD_BADD = 3'd3,
        CMD_BREM = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        CT_CREATE = 2'd0,
        CT_DELETE = 2'd1,
        CT_MOVE   = 2'd2
    } t_ctype;

    typedef enum logic [1:0] {
        KIND_INVALID = 2'd0,
        KIND_CREATE  = 2'd1,
        KIND_DELETE  = 2'd2,
        KIND_MOVE    = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ACT_NONE    = 3'd0,
        ACT_REMOVE  = 3'd1,
        ACT_RESTORE = 3'd2,
        ACT_SETPOS  = 3'd3,
        ACT_EVICT   = 3'd4,
        ACT_MISSING = 3'd5,
        ACT_FULL    = 3'd6
    } t_act;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_ADD_WR,
        S_UNDO_CHK,
        S_RSCAN,
        S_BSCAN,
        S_REDO_CHK,
        S_BADD_SCAN,
        S_BREM_SCAN,
        S_FIN
    } t_state;

    typedef struct packed {
        t_kind       kind;
        logic [31:0] obj;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
    } t_rword;

    typedef struct packed {
        logic [31:0] obj;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
    } t_bword;

    // True when x lies in the circular span from lo to hi, both ends included.
    function automatic logic in_span(t_rptr x, t_rptr lo, t_rptr hi);
        logic r;
        if (hi > lo) r = (x >= lo) && (x <= hi);
        else         r = (x >= lo) || (x <= hi);
        return r;
    endfunction

endpackage
`default_nettype wire

>>> rtl/undo_history_ring.sv
`default_nettype none
// Undo/redo history ring. One command word enters at a time and gives exactly one result
// word. Undo of a move walks the history backward from the cursor toward the tail, one
// ring read per cycle, and, if no earlier move of that object turns up, then the base
// table, one read per cycle. Base add scans the base valid bits one per cycle. The rate is
// set by the single read port of each of the two entry memories. A finished result waits in
// the output register while the next command word is taken.
module undo_history_ring (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [2:0]  i_command,
    input  wire logic [1:0]  i_change_type,
    input  wire logic [31:0] i_object_id,
    input  wire logic [31:0] i_pos_x,
    input  wire logic [31:0] i_pos_y,
    input  wire logic [31:0] i_pos_z,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [2:0]       o_action,
    output logic [1:0]       o_evicted_type,
    output logic [31:0]      o_out_object,
    output logic [31:0]      o_out_x,
    output logic [31:0]      o_out_y,
    output logic [31:0]      o_out_z,
    output logic             o_at_start,
    output logic             o_at_end,
    output logic             o_is_empty,
    output logic [7:0]       o_cursor
);
    import uhr_pkg::*;

    t_state r_state, n_state;
    logic [2:0] r_cmd;
    logic [1:0] r_ct;
    logic [31:0] r_obj, r_px, r_py, r_pz;
    t_rptr r_head, n_head, r_tail, n_tail, r_cursor, n_cursor;
    t_rptr r_idx, n_idx, r_pidx, n_pidx;
    logic r_pvld, n_pvld, r_plast, n_plast;
    t_bptr r_bidx, n_bidx, r_bpidx, n_bpidx;
    logic r_bpvld, n_bpvld, r_bplast, n_bplast;
    logic [RING_DEPTH-1:0] r_rvalid;
    logic [BASE_DEPTH-1:0] r_bvalid;
    logic rv_set, bv_set, bv_clr;
    t_act r_act, n_act;
    logic [1:0] r_ety, n_ety;
    logic [31:0] r_robj, n_robj, r_rx, n_rx, r_ry, n_ry, r_rz, n_rz;
    logic r_ovalid, load_out;

    logic ring_we;
    t_rptr ring_raddr;
    t_rword ring_wdata, ring_rd;
    logic base_we;
    t_bptr base_waddr, base_raddr;
    t_bword base_rd;

    t_rptr prev_c, next_c;
    t_kind cur_kind;
    logic accept;

    uhr_ram #(.DEPTH(RING_DEPTH), .WIDTH($bits(t_rword))) u_ring (
        .i_clk  (i_clk),
        .i_we   (ring_we),
        .i_waddr(r_cursor),
        .i_wdata(ring_wdata),
        .i_raddr(ring_raddr),
        .o_rdata(ring_rd)
    );

    uhr_ram #(.DEPTH(BASE_DEPTH), .WIDTH($bits(t_bword))) u_base (
        .i_clk  (i_clk),
        .i_we   (base_we),
        .i_waddr(base_waddr),
        .i_wdata({r_obj, r_px, r_py, r_pz}),
        .i_raddr(base_raddr),
        .o_rdata(base_rd)
    );

    assign o_stall  = (r_state != S_IDLE);
    assign accept   = i_valid && !o_stall;
    assign load_out = (r_state == S_FIN) && (!r_ovalid || !i_stall);
    assign o_valid  = r_ovalid;
    assign prev_c   = r_cursor - t_rptr'(1);
    assign next_c   = r_cursor + t_rptr'(1);
    assign cur_kind = r_rvalid[r_cursor] ? ring_rd.kind : KIND_INVALID;

    always_comb begin
        n_state  = r_state;
        n_head   = r_head;
        n_tail   = r_tail;
        n_cursor = r_cursor;
        n_idx    = r_idx;
        n_pidx   = r_pidx;
        n_pvld   = r_pvld;
        n_plast  = r_plast;
        n_bidx   = r_bidx;
        n_bpidx  = r_bpidx;
        n_bpvld  = r_bpvld;
        n_bplast = r_bplast;
        n_act    = r_act;
        n_ety    = r_ety;
        n_robj   = r_robj;
        n_rx     = r_rx;
        n_ry     = r_ry;
        n_rz     = r_rz;
        rv_set   = 1'b0;
        bv_set   = 1'b0;
        bv_clr   = 1'b0;
        ring_we  = 1'b0;
        ring_raddr = r_cursor;
        ring_wdata.kind = t_kind'(r_ct + 2'd1);
        ring_wdata.obj  = r_obj;
        ring_wdata.x    = (r_ct == CT_MOVE) ? r_px : 32'd0;
        ring_wdata.y    = (r_ct == CT_MOVE) ? r_py : 32'd0;
        ring_wdata.z    = (r_ct == CT_MOVE) ? r_pz : 32'd0;
        base_we    = 1'b0;
        base_waddr = r_bidx;
        base_raddr = r_bidx;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_act  = ACT_NONE;
                    n_ety  = 2'd0;
                    n_robj = 32'd0;
                    n_rx   = 32'd0;
                    n_ry   = 32'd0;
                    n_rz   = 32'd0;
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                n_state = S_FIN;
                n_pvld  = 1'b0;
                n_bpvld = 1'b0;
                n_bidx  = '0;
                case (r_cmd)
                    CMD_ADD: begin
                        if (r_ct != 2'd3) begin
                            n_state = S_ADD_WR;
                        end
                    end
                    CMD_UNDO: begin
                        if (r_cursor != r_tail && r_head != r_tail) begin
                            if (in_span(prev_c, r_tail, r_head)) begin
                                n_cursor   = prev_c;
                                ring_raddr = prev_c;
                            end
                            n_state = S_UNDO_CHK;
                        end
                    end
                    CMD_REDO: begin
                        if (r_cursor != r_head) begin
                            n_state = S_REDO_CHK;
                        end
                    end
                    CMD_BADD: n_state = S_BADD_SCAN;
                    CMD_BREM: n_state = S_BREM_SCAN;
                    default: n_state = S_FIN;
                endcase
            end
            S_ADD_WR: begin
                ring_we  = 1'b1;
                rv_set   = 1'b1;
                n_head   = next_c;
                n_cursor = next_c;
                if (next_c == r_tail) begin
                    n_tail = r_tail + t_rptr'(1);
                    if (r_rvalid[r_cursor]) begin
                        n_act  = ACT_EVICT;
                        n_ety  = ring_rd.kind - 2'd1;
                        n_robj = ring_rd.obj;
                        n_rx   = ring_rd.x;
                        n_ry   = ring_rd.y;
                        n_rz   = ring_rd.z;
                    end
                end
                n_state = S_FIN;
            end
            S_UNDO_CHK: begin
                n_robj  = ring_rd.obj;
                n_state = S_FIN;
                case (cur_kind)
                    KIND_CREATE: n_act = ACT_REMOVE;
                    KIND_DELETE: n_act = ACT_RESTORE;
                    KIND_MOVE: begin
                        if (r_cursor != r_tail) begin
                            n_idx   = prev_c;
                            n_state = S_RSCAN;
                        end else begin
                            n_state = S_BSCAN;
                        end
                    end
                    default: n_robj = 32'd0;
                endcase
            end
            S_RSCAN: begin
                // The read issued last cycle is checked while the next one goes out.
                if (r_pvld && r_rvalid[r_pidx] && ring_rd.kind == KIND_MOVE
                        && ring_rd.obj == r_robj) begin
                    n_act   = ACT_SETPOS;
                    n_rx    = ring_rd.x;
                    n_ry    = ring_rd.y;
                    n_rz    = ring_rd.z;
                    n_state = S_FIN;
                end else if (r_pvld && r_plast) begin
                    n_bidx  = '0;
                    n_state = S_BSCAN;
                end else begin
                    ring_raddr = r_idx;
                    n_pidx  = r_idx;
                    n_pvld  = 1'b1;
                    n_plast = (r_idx == r_tail);
                    n_idx   = r_idx - t_rptr'(1);
                end
            end
            S_BSCAN: begin
                if (r_bpvld && r_bvalid[r_bpidx] && base_rd.obj == r_robj) begin
                    n_act   = ACT_SETPOS;
                    n_rx    = base_rd.x;
                    n_ry    = base_rd.y;
                    n_rz    = base_rd.z;
                    n_state = S_FIN;
                end else if (r_bpvld && r_bplast) begin
                    n_act   = ACT_MISSING;
                    n_state = S_FIN;
                end else begin
                    n_bpidx  = r_bidx;
                    n_bpvld  = 1'b1;
                    n_bplast = (r_bidx == t_bptr'(BASE_DEPTH - 1));
                    n_bidx   = r_bidx + t_bptr'(1);
                end
            end
            S_REDO_CHK: begin
                case (cur_kind)
                    KIND_CREATE: begin
                        n_act  = ACT_RESTORE;
                        n_robj = ring_rd.obj;
                    end
                    KIND_DELETE: begin
                        n_act  = ACT_REMOVE;
                        n_robj = ring_rd.obj;
                    end
                    KIND_MOVE: begin
                        n_act  = ACT_SETPOS;
                        n_robj = ring_rd.obj;
                        n_rx   = ring_rd.x;
                        n_ry   = ring_rd.y;
                        n_rz   = ring_rd.z;
                    end
                    default: n_act = ACT_NONE;
                endcase
                if (in_span(next_c, r_tail, r_head)) begin
                    n_cursor = next_c;
                end
                n_state = S_FIN;
            end
            S_BADD_SCAN: begin
                if (!r_bvalid[r_bidx]) begin
                    base_we = 1'b1;
                    bv_set  = 1'b1;
                    n_state = S_FIN;
                end else if (r_bidx == t_bptr'(BASE_DEPTH - 1)) begin
                    n_act   = ACT_FULL;
                    n_robj  = r_obj;
                    n_state = S_FIN;
                end else begin
                    n_bidx = r_bidx + t_bptr'(1);
                end
            end
            S_BREM_SCAN: begin
                if (r_bpvld && r_bvalid[r_bpidx] && base_rd.obj == r_obj) begin
                    bv_clr  = 1'b1;
                    n_state = S_FIN;
                end else if (r_bpvld && r_bplast) begin
                    n_state = S_FIN;
                end else begin
                    n_bpidx  = r_bidx;
                    n_bpvld  = 1'b1;
                    n_bplast = (r_bidx == t_bptr'(BASE_DEPTH - 1));
                    n_bidx   = r_bidx + t_bptr'(1);
                end
            end
            S_FIN: begin
                if (load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_head   <= '0;
            r_tail   <= '0;
            r_cursor <= '0;
            r_rvalid <= '0;
            r_bvalid <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_head   <= n_head;
            r_tail   <= n_tail;
            r_cursor <= n_cursor;
            if (rv_set) begin
                r_rvalid[r_cursor] <= 1'b1;
            end
            if (bv_set) begin
                r_bvalid[r_bidx] <= 1'b1;
            end
            if (bv_clr) begin
                r_bvalid[r_bpidx] <= 1'b0;
            end
            if (load_out) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= i_command;
            r_ct  <= i_change_type;
            r_obj <= i_object_id;
            r_px  <= i_pos_x;
            r_py  <= i_pos_y;
            r_pz  <= i_pos_z;
        end
        r_idx    <= n_idx;
        r_pidx   <= n_pidx;
        r_pvld   <= n_pvld;
        r_plast  <= n_plast;
        r_bidx   <= n_bidx;
        r_bpidx  <= n_bpidx;
        r_bpvld  <= n_bpvld;
        r_bplast <= n_bplast;
        r_act    <= n_act;
        r_ety    <= n_ety;
        r_robj   <= n_robj;
        r_rx     <= n_rx;
        r_ry     <= n_ry;
        r_rz     <= n_rz;
        if (load_out) begin
            o_action       <= r_act;
            o_evicted_type <= r_ety;
            o_out_object   <= r_robj;
            o_out_x        <= r_rx;
            o_out_y        <= r_ry;
            o_out_z        <= r_rz;
            o_at_start     <= (r_cursor == r_tail);
            o_at_end       <= (r_cursor == r_head);
            o_is_empty     <= (r_head == r_tail);
            o_cursor       <= 8'(r_cursor);
        end
    end

    a_cursor_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_span(r_cursor, r_tail, r_head))
        else $error("cursor outside the live span");

    a_newest_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_head != r_tail) |-> r_rvalid[r_head - t_rptr'(1)])
        else $error("newest entry not marked valid");

    a_fin_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && load_out) |=> (o_valid && r_state == S_IDLE))
        else $error("result word not presented");

    a_scan_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (!ring_we && !base_we))
        else $error("memory written while idle");
endmodule
`default_nettype wire

>>> rtl/uhr_ram.sv
`default_nettype none
module uhr_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire
